### src/bb2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb2d_pkg
// Shared constants and types of the 2x2 box blur with decay.
// ----------------------------------------------------------------------------
package bb2d_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DECAY_AMOUNT = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 7'd45;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 7'd35;
    localparam logic [PIX_W-1:0] DECAY_AMOUNT_RST = 8'd8;

    // position flags of one pixel, used to build its result set
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic last_col;
        logic last_row;
    } pos_flags_t;

endpackage

### src/bb2d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb2d_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module bb2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/bb2d_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb2d_pos
// Input stage: raster position tracking, line store access and the
// holding register of the pixel whose upper neighbour is being read.
// ----------------------------------------------------------------------------
module bb2d_pos #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bb2d_pkg::PIX_W-1:0]           s_pixel_value,
    input  logic                                 s_frame_start,
    input  logic [bb2d_pkg::CFG_W-1:0]           cfg_width,
    input  logic [bb2d_pkg::CFG_W-1:0]           cfg_height,
    input  logic                                 advance,
    output logic                                 ram_en,
    output logic [$clog2(MAX_WIDTH)-1:0]         ram_addr,
    output logic [bb2d_pkg::PIX_W-1:0]           ram_wdata,
    output logic                                 s1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]         s1_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]        s1_row,
    output logic [bb2d_pkg::PIX_W-1:0]           s1_pixel,
    output logic [bb2d_pkg::PIX_W-1:0]           s1_left,
    output bb2d_pkg::pos_flags_t                 s1_flags
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > bb2d_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : bb2d_pkg::CFG_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > bb2d_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : bb2d_pkg::CFG_W;

    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [bb2d_pkg::PIX_W-1:0] left_reg;
    logic                       s1_valid_reg;
    logic [CW-1:0]              s1_col_reg;
    logic [RW-1:0]              s1_row_reg;
    logic [bb2d_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [bb2d_pkg::PIX_W-1:0] s1_left_reg;
    bb2d_pkg::pos_flags_t       s1_flags_reg;

    logic [WW-1:0]        w_eff, c_w, c_inc;
    logic [HW-1:0]        h_eff, r_w, r_inc;
    logic                 accept;
    bb2d_pkg::pos_flags_t cur_flags;

    always_comb begin
        w_eff = WW'(cfg_width);
        if (w_eff < WW'(2)) begin
            w_eff = WW'(2);
        end else if (w_eff > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = HW'(cfg_height);
        if (h_eff < HW'(2)) begin
            h_eff = HW'(2);
        end else if (h_eff > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end
    end

    always_comb begin
        c_w = s_frame_start ? '0 : WW'(col_reg);
        r_w = s_frame_start ? '0 : HW'(row_reg);
        if (c_w >= w_eff) begin
            c_w = '0;
            r_w = r_w + HW'(1);
        end
        if (r_w >= h_eff) begin
            r_w = '0;
        end
        cur_flags.has_up   = (r_w != '0);
        cur_flags.has_left = (c_w != '0);
        cur_flags.last_col = (c_w == w_eff - WW'(1));
        cur_flags.last_row = (r_w == h_eff - HW'(1));
        c_inc = c_w + WW'(1);
        r_inc = r_w;
        if (c_inc >= w_eff) begin
            c_inc = '0;
            r_inc = r_w + HW'(1);
            if (r_inc >= h_eff) begin
                r_inc = '0;
            end
        end
        col_next = CW'(c_inc);
        row_next = RW'(r_inc);
    end

    assign s_ready   = !s1_valid_reg || advance;
    assign accept    = s_valid && s_ready;
    assign ram_en    = accept;
    assign ram_addr  = CW'(c_w);
    assign ram_wdata = s_pixel_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                left_reg     <= s_pixel_value;
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= CW'(c_w);
            s1_row_reg   <= RW'(r_w);
            s1_pixel_reg <= s_pixel_value;
            s1_left_reg  <= left_reg;
            s1_flags_reg <= cur_flags;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;
    assign s1_pixel = s1_pixel_reg;
    assign s1_left  = s1_left_reg;
    assign s1_flags = s1_flags_reg;

endmodule

### src/bb2d_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb2d_emit
// Blur arithmetic on the pixel, its line store neighbour and the held
// neighbours, and a result buffer emitting one transaction per m_ready cycle.
// ----------------------------------------------------------------------------
module bb2d_emit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s1_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]         s1_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]        s1_row,
    input  logic [bb2d_pkg::PIX_W-1:0]           s1_pixel,
    input  logic [bb2d_pkg::PIX_W-1:0]           s1_left,
    input  bb2d_pkg::pos_flags_t                 s1_flags,
    input  logic [bb2d_pkg::PIX_W-1:0]           up_pixel,
    input  logic [bb2d_pkg::PIX_W-1:0]           decay,
    output logic                                 advance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bb2d_pkg::COORD_W-1:0]         m_out_col,
    output logic [bb2d_pkg::COORD_W-1:0]         m_out_row,
    output logic [bb2d_pkg::PIX_W-1:0]           m_out_value,
    output logic                                 m_run_last,
    output logic                                 m_frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int NRES  = 4;
    localparam int SUM_W = bb2d_pkg::PIX_W + 2;

    localparam logic [1:0] RES_INNER  = 2'd0;
    localparam logic [1:0] RES_RIGHT  = 2'd1;
    localparam logic [1:0] RES_BOTTOM = 2'd2;
    localparam logic [1:0] RES_CORNER = 2'd3;

    function automatic logic [bb2d_pkg::PIX_W-1:0] decayed(
        input logic [SUM_W-1:0]           sum,
        input logic [bb2d_pkg::PIX_W-1:0] amount
    );
        logic [bb2d_pkg::PIX_W-1:0] dot;
        dot = sum[SUM_W-1:2];
        return (dot <= amount) ? '0 : dot - amount;
    endfunction

    logic [NRES-1:0]            mask_reg, mask_next;
    logic [bb2d_pkg::PIX_W-1:0] val_reg [NRES];
    logic [CW-1:0]              col_reg, colm1_reg;
    logic [RW-1:0]              row_reg, rowm1_reg;
    logic [bb2d_pkg::PIX_W-1:0] ul_reg;

    logic [NRES-1:0]            new_mask, sel_oh;
    logic [1:0]                 sel_idx;
    logic [SUM_W-1:0]           sum_inner, sum_right, sum_bottom;
    logic                       out_fire, last_pending, can_load;

    assign sum_inner  = SUM_W'(ul_reg) + SUM_W'(up_pixel) + SUM_W'(s1_left)
                        + SUM_W'(s1_pixel);
    assign sum_right  = SUM_W'(up_pixel) + SUM_W'(s1_pixel);
    assign sum_bottom = SUM_W'(s1_left) + SUM_W'(s1_pixel);

    always_comb begin
        new_mask             = '0;
        new_mask[RES_INNER]  = s1_flags.has_up && s1_flags.has_left;
        new_mask[RES_RIGHT]  = s1_flags.has_up && s1_flags.last_col;
        new_mask[RES_BOTTOM] = s1_flags.last_row && s1_flags.has_left;
        new_mask[RES_CORNER] = s1_flags.last_row && s1_flags.last_col;
    end

    always_comb begin
        sel_idx = RES_CORNER;
        for (int i = NRES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_idx = 2'(i);
            end
        end
        sel_oh          = '0;
        sel_oh[sel_idx] = 1'b1;
    end

    assign m_valid      = (mask_reg != '0);
    assign out_fire     = m_valid && m_ready;
    assign last_pending = ((mask_reg & (mask_reg - NRES'(1))) == '0);
    assign can_load     = !m_valid || (out_fire && last_pending);
    assign advance      = s1_valid && can_load;

    always_comb begin
        mask_next = mask_reg;
        if (advance) begin
            mask_next = new_mask;
        end else if (out_fire) begin
            mask_next = mask_reg & ~sel_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            ul_reg   <= '0;
        end else begin
            mask_reg <= mask_next;
            if (advance) begin
                ul_reg <= up_pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            val_reg[RES_INNER]  <= decayed(sum_inner, decay);
            val_reg[RES_RIGHT]  <= decayed(sum_right, decay);
            val_reg[RES_BOTTOM] <= decayed(sum_bottom, decay);
            val_reg[RES_CORNER] <= '0;
            col_reg             <= s1_col;
            colm1_reg           <= s1_col - CW'(1);
            row_reg             <= s1_row;
            rowm1_reg           <= s1_row - RW'(1);
        end
    end

    always_comb begin
        case (sel_idx)
            RES_INNER: begin
                m_out_col = bb2d_pkg::COORD_W'(colm1_reg);
                m_out_row = bb2d_pkg::COORD_W'(rowm1_reg);
            end
            RES_RIGHT: begin
                m_out_col = bb2d_pkg::COORD_W'(col_reg);
                m_out_row = bb2d_pkg::COORD_W'(rowm1_reg);
            end
            RES_BOTTOM: begin
                m_out_col = bb2d_pkg::COORD_W'(colm1_reg);
                m_out_row = bb2d_pkg::COORD_W'(row_reg);
            end
            default: begin
                m_out_col = bb2d_pkg::COORD_W'(col_reg);
                m_out_row = bb2d_pkg::COORD_W'(row_reg);
            end
        endcase
    end

    assign m_out_value  = val_reg[sel_idx];
    assign m_run_last   = last_pending;
    assign m_frame_done = (sel_idx == RES_CORNER);

endmodule

### src/box_blur_2x2_decay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_2x2_decay
// Streaming 2x2 box blur with decay over a raster pixel stream.
// ----------------------------------------------------------------------------
// At most one pixel is accepted per clock. Each pixel completes 0 to 4 blurred
// results, which leave one transaction per clock while the result port is
// ready. A pixel holds the input until its last result leaves. With the
// result port always ready, a full-rate input slows at the last column of
// every row from row 1 on, at each pixel of the bottom row after column 0, and
// most at the lower-right corner. Stalls on the result port add to this. The
// previous row sits in a dual-port line store of MAX_WIDTH entries, read and
// rewritten at the pixel's column in the cycle it is accepted. Pixels are
// registered in the input stage, results in the result buffer. Configuration
// is written over the APB port (frame_width at 0x0, frame_height at 0x4,
// decay_amount at 0x8) while the block is idle, which only the user ensures.
module box_blur_2x2_decay #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bb2d_pkg::APB_AW-1:0]     paddr,
    input  logic [bb2d_pkg::APB_DW-1:0]     pwdata,
    output logic [bb2d_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bb2d_pkg::PIX_W-1:0]      s_pixel_value,
    input  logic                            s_frame_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bb2d_pkg::COORD_W-1:0]    m_out_col,
    output logic [bb2d_pkg::COORD_W-1:0]    m_out_row,
    output logic [bb2d_pkg::PIX_W-1:0]      m_out_value,
    output logic                            m_run_last,
    output logic                            m_frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [bb2d_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [bb2d_pkg::PIX_W-1:0] decay_amount_reg;
    logic                       cfg_write;

    logic                       advance, ram_en, s1_valid;
    logic [CW-1:0]              ram_addr, s1_col;
    logic [RW-1:0]              s1_row;
    logic [bb2d_pkg::PIX_W-1:0] ram_wdata, ram_rdata, s1_pixel, s1_left;
    bb2d_pkg::pos_flags_t       s1_flags;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bb2d_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bb2d_pkg::FRAME_HEIGHT_RST;
            decay_amount_reg <= bb2d_pkg::DECAY_AMOUNT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                bb2d_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= pwdata[bb2d_pkg::CFG_W-1:0];
                end
                bb2d_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= pwdata[bb2d_pkg::CFG_W-1:0];
                end
                bb2d_pkg::REG_DECAY_AMOUNT: begin
                    decay_amount_reg <= pwdata[bb2d_pkg::PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bb2d_pkg::REG_FRAME_WIDTH:  prdata = bb2d_pkg::APB_DW'(frame_width_reg);
            bb2d_pkg::REG_FRAME_HEIGHT: prdata = bb2d_pkg::APB_DW'(frame_height_reg);
            bb2d_pkg::REG_DECAY_AMOUNT: prdata = bb2d_pkg::APB_DW'(decay_amount_reg);
            default:                    prdata = '0;
        endcase
    end

    bb2d_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_frame_start (s_frame_start),
        .cfg_width     (frame_width_reg),
        .cfg_height    (frame_height_reg),
        .advance       (advance),
        .ram_en        (ram_en),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .s1_valid      (s1_valid),
        .s1_col        (s1_col),
        .s1_row        (s1_row),
        .s1_pixel      (s1_pixel),
        .s1_left       (s1_left),
        .s1_flags      (s1_flags)
    );

    bb2d_ram #(
        .WIDTH (bb2d_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (ram_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    bb2d_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s1_valid     (s1_valid),
        .s1_col       (s1_col),
        .s1_row       (s1_row),
        .s1_pixel     (s1_pixel),
        .s1_left      (s1_left),
        .s1_flags     (s1_flags),
        .up_pixel     (ram_rdata),
        .decay        (decay_amount_reg),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_out_value  (m_out_value),
        .m_run_last   (m_run_last),
        .m_frame_done (m_frame_done)
    );

endmodule

### src/bb2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb2d_checker
// Port-level checks of the blur block, bound to the top level.
// ----------------------------------------------------------------------------
module bb2d_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            pready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [bb2d_pkg::COORD_W-1:0]    m_out_col,
    input logic [bb2d_pkg::COORD_W-1:0]    m_out_row,
    input logic [bb2d_pkg::PIX_W-1:0]      m_out_value,
    input logic                            m_run_last,
    input logic                            m_frame_done
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_col) && $stable(m_out_row)
            && $stable(m_out_value) && $stable(m_run_last) && $stable(m_frame_done))
        else $error("result changed while stalled");

    // corner result closes the set of its pixel
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_run_last)
        else $error("frame_done without run_last");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_out_value == '0)
        else $error("corner value not zero");

    // rest of a result set follows without a gap
    a_set_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("result set interrupted");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind box_blur_2x2_decay bb2d_checker u_bb2d_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .pready       (pready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_col    (m_out_col),
    .m_out_row    (m_out_row),
    .m_out_value  (m_out_value),
    .m_run_last   (m_run_last),
    .m_frame_done (m_frame_done)
);
